// File: rtl/psv_pkg.sv
package psv_pkg;

    localparam int LIMIT_W = 11;
    localparam int PRIME_W = 11;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd2000;

    typedef struct packed {
        logic wr_en;
        logic wr_bit;
        logic rd_en;
    } t_map_cmd;

endpackage

// File: rtl/prime_sieve_stream.sv
// Channel   Direction  Signals                             Transaction
// request   in         start, busy, i_restart              start && !busy
// result    out        o_strobe, o_prime, o_last           o_strobe, one cycle
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_limit  i_cfg_valid && o_cfg_ready
//
// A sieve run seeds the bitmap from 0 to the limit, then for each candidate i with
// i*i <= limit reads its bit and marks the multiples of each prime from i*i on; the
// single write port and the shared adder serialize these steps. A request stays busy
// scanning each number up to the prime after the returned one, or past the limit.
// Reset is synchronous, active low; the bitmap needs no clearing. The receiver
// cannot stall: each result is shown for one cycle, in the cycle busy falls.
module prime_sieve_stream
    import psv_pkg::*;
#(
    parameter int MAX_NUMBER = 2047
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_restart,
    output logic               o_strobe,
    output logic [PRIME_W-1:0] o_prime,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_limit
);

    localparam int DEPTH = MAX_NUMBER + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = 2 * AW;
    localparam int CW    = (AW > LIMIT_W) ? AW : LIMIT_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INIT    = 3'd1;
    localparam logic [2:0] S_SV_CHK  = 3'd2;
    localparam logic [2:0] S_SV_WAIT = 3'd3;
    localparam logic [2:0] S_SV_MARK = 3'd4;
    localparam logic [2:0] S_SV_NEXT = 3'd5;
    localparam logic [2:0] S_SC_RD   = 3'd6;
    localparam logic [2:0] S_SC_CHK  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [AW-1:0]      r_lim, n_lim;
    logic [AW-1:0]      r_i, n_i;
    logic [SW-1:0]      r_sq, n_sq;
    logic [AW:0]        r_j, n_j;
    logic [AW:0]        r_addr, n_addr;
    logic [AW-1:0]      r_cursor, n_cursor;
    logic [AW-1:0]      r_p, n_p;
    logic               r_find, n_find;
    logic               r_map_ready, n_map_ready;
    logic               r_strobe, n_strobe;
    logic               r_last, n_last;
    logic [PRIME_W-1:0] r_prime, n_prime;

    logic [CW-1:0]      lim_c;
    logic [AW-1:0]      eff_lim;
    logic [SW-1:0]      alu_a, alu_b, alu_sum;
    logic               alu_cin, alu_over;
    t_map_cmd           map_cmd;
    logic [AW-1:0]      map_waddr, map_raddr;
    logic               map_rdata;
    logic [AW+PRIME_W-1:0] p_wide;

    // saturate the configured limit to the bitmap size
    assign lim_c   = CW'(r_limit);
    assign eff_lim = (lim_c > CW'(MAX_NUMBER)) ? AW'(MAX_NUMBER) : AW'(lim_c);
    assign p_wide  = (AW+PRIME_W)'(r_p);

    psv_adder #(.SW(SW)) u_adder (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_cin  (alu_cin),
        .i_lim  (SW'(r_lim)),
        .o_sum  (alu_sum),
        .o_over (alu_over)
    );

    psv_map #(.AW(AW), .DEPTH(DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_cmd   (map_cmd),
        .i_waddr (map_waddr),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    always_comb begin
        alu_a     = '0;
        alu_b     = '0;
        alu_cin   = 1'b0;
        map_cmd   = '0;
        map_waddr = r_i;
        map_raddr = r_i;
        unique case (r_state)
            S_INIT: begin
                alu_a          = SW'(r_i);
                alu_cin        = 1'b1;
                map_cmd.wr_en  = 1'b1;
                map_cmd.wr_bit = (r_i < AW'(2));
            end
            S_SV_CHK: begin
                alu_a         = r_sq;
                map_cmd.rd_en = 1'b1;
            end
            S_SV_MARK: begin
                alu_a          = SW'(r_j);
                alu_b          = SW'(r_i);
                map_cmd.wr_en  = 1'b1;
                map_cmd.wr_bit = 1'b1;
                map_waddr      = r_j[AW-1:0];
            end
            S_SV_NEXT: begin
                alu_a   = r_sq;
                alu_b   = SW'({r_i, 1'b0});
                alu_cin = 1'b1;
            end
            S_SC_RD: begin
                alu_a         = SW'(r_addr);
                map_cmd.rd_en = 1'b1;
                map_raddr     = r_addr[AW-1:0];
            end
            S_SC_CHK: begin
                alu_a   = SW'(r_addr);
                alu_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_lim       = r_lim;
        n_i         = r_i;
        n_sq        = r_sq;
        n_j         = r_j;
        n_addr      = r_addr;
        n_cursor    = r_cursor;
        n_p         = r_p;
        n_find      = r_find;
        n_map_ready = r_map_ready;
        n_strobe    = 1'b0;
        n_last      = r_last;
        n_prime     = r_prime;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_find = 1'b0;
                    if (i_restart || !r_map_ready) begin
                        n_lim   = eff_lim;
                        n_i     = '0;
                        n_state = S_INIT;
                    end else begin
                        n_addr  = {1'b0, r_cursor};
                        n_state = S_SC_RD;
                    end
                end
            end
            S_INIT: begin
                if (alu_over) begin
                    n_i     = AW'(2);
                    n_sq    = SW'(4);
                    n_state = S_SV_CHK;
                end else begin
                    n_i = alu_sum[AW-1:0];
                end
            end
            S_SV_CHK: begin
                // done sieving once i*i passes the limit
                if (alu_over) begin
                    n_map_ready = 1'b1;
                    n_addr      = (AW+1)'(2);
                    n_state     = S_SC_RD;
                end else begin
                    n_state = S_SV_WAIT;
                end
            end
            S_SV_WAIT: begin
                if (!map_rdata) begin
                    n_j     = r_sq[AW:0];
                    n_state = S_SV_MARK;
                end else begin
                    n_state = S_SV_NEXT;
                end
            end
            S_SV_MARK: begin
                n_j = alu_sum[AW:0];
                if (alu_over) begin
                    n_state = S_SV_NEXT;
                end
            end
            S_SV_NEXT: begin
                // (i+1)^2 = i^2 + 2i + 1
                n_sq    = alu_sum;
                n_i     = r_i + AW'(1);
                n_state = S_SV_CHK;
            end
            S_SC_RD: begin
                if (alu_over) begin
                    // ran past the limit: finish the list
                    n_map_ready = 1'b0;
                    n_state     = S_IDLE;
                    if (r_find) begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                        n_prime  = p_wide[PRIME_W-1:0];
                    end
                end else begin
                    n_state = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                if (!map_rdata && r_find) begin
                    // lookahead found the next prime: hold it as the cursor
                    n_strobe = 1'b1;
                    n_last   = 1'b0;
                    n_prime  = p_wide[PRIME_W-1:0];
                    n_cursor = r_addr[AW-1:0];
                    n_state  = S_IDLE;
                end else begin
                    if (!map_rdata) begin
                        n_p    = r_addr[AW-1:0];
                        n_find = 1'b1;
                    end
                    n_addr  = alu_sum[AW:0];
                    n_state = S_SC_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_lim       <= '0;
            r_cursor    <= '0;
            r_map_ready <= 1'b0;
            r_strobe    <= 1'b0;
            r_find      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lim       <= n_lim;
            r_cursor    <= n_cursor;
            r_map_ready <= n_map_ready;
            r_strobe    <= n_strobe;
            r_find      <= n_find;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_sq    <= n_sq;
        r_j     <= n_j;
        r_addr  <= n_addr;
        r_p     <= n_p;
        r_last  <= n_last;
        r_prime <= n_prime;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_prime     = r_prime;
    assign o_last      = r_last;

endmodule

// File: rtl/psv_map.sv
module psv_map
    import psv_pkg::*;
#(
    parameter int AW    = 11,
    parameter int DEPTH = 2048
) (
    input  logic          i_clk,
    input  t_map_cmd      i_cmd,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    // one bit per number, 1 = composite
    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_waddr] <= i_cmd.wr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/psv_adder.sv
module psv_adder
    import psv_pkg::*;
#(
    parameter int SW = 22
) (
    input  logic [SW-1:0] i_a,
    input  logic [SW-1:0] i_b,
    input  logic          i_cin,
    input  logic [SW-1:0] i_lim,
    output logic [SW-1:0] o_sum,
    output logic          o_over
);

    // shared step unit: one add, then compare the sum against the run limit
    assign o_sum  = i_a + i_b + SW'(i_cin);
    assign o_over = (o_sum > i_lim);

endmodule
